/* src/b2da_pkg.sv */
// Shared types and constants for the binary to decimal ASCII converter.
// No dependencies; imported by b2da_dabble and binary_to_decimal_ascii_top.

package b2da_pkg;

   // Width of one BCD digit.
   localparam int unsigned DIGIT_BITS = 4;

   // ASCII code of the character '0'.
   localparam logic [5:0] ASCII_ZERO = 6'd48;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

   // Control from the sequencer to the conversion datapath.
   typedef struct packed {
      logic load;         // capture a new value and clear the BCD register
      logic dabble;       // one shift-add-3 step
      logic digit_shift;  // move the BCD register up by one digit
   } dbl_ctrl_type;

endpackage

/* src/b2da_dabble.sv */
// Double dabble datapath: binary shift register feeding a BCD shift register.
// Depends on b2da_pkg for the control struct and digit width.

module b2da_dabble #(
   parameter int unsigned VALUE_BITS = 64,
   parameter int unsigned NUM_DIGITS = 20
) (
   input  logic                     clock,
   input  b2da_pkg::dbl_ctrl_type   ctrl,
   input  logic [VALUE_BITS-1:0]    load_value,
   output logic [3:0]               top_digit
);
   import b2da_pkg::*;

   localparam int unsigned BCD_BITS = NUM_DIGITS * DIGIT_BITS;

   logic [VALUE_BITS-1:0] bin_ff, bin_in;
   logic [BCD_BITS-1:0]   bcd_ff, bcd_in;
   logic [BCD_BITS-1:0]   bcd_adj;

   // Add-3 correction on every digit that is five or more, ahead of the shift.
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i*DIGIT_BITS +: DIGIT_BITS] >= 4'd5) begin
            bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd_ff[i*DIGIT_BITS +: DIGIT_BITS] + 4'd3;
         end else begin
            bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd_ff[i*DIGIT_BITS +: DIGIT_BITS];
         end
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      if (ctrl.load) begin
         bin_in = load_value;
         bcd_in = '0;
      end else if (ctrl.dabble) begin
         bin_in = {bin_ff[VALUE_BITS-2:0], 1'b0};
         bcd_in = {bcd_adj[BCD_BITS-2:0], bin_ff[VALUE_BITS-1]};
      end else if (ctrl.digit_shift) begin
         bcd_in = {bcd_ff[BCD_BITS-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign top_digit = bcd_ff[BCD_BITS-1 -: DIGIT_BITS];

endmodule

/* src/binary_to_decimal_ascii_top.sv */
// Binary to decimal ASCII converter, one VALUE_BITS-bit value per item.
// The value is loaded at the accepting edge; VALUE_BITS shift-add-3 steps follow, then a
// readout of NUM_DIGITS digits drops leading zeros and shows each digit for one cycle. A new
// item is taken only in idle, after the bit-serial double dabble loop and the digit-serial
// readout of the last one are done, so items do not overlap. The receiver cannot stall.
// Synchronous active-high reset returns the sequencer to idle; data registers are not reset.

module binary_to_decimal_ascii_top #(
   parameter int unsigned VALUE_BITS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   output logic [5:0]            rsp_digit_char,
   output logic                  rsp_last_digit
);
   import b2da_pkg::*;

   // Decimal length of the largest value: floor(VALUE_BITS * log10(2)) + 1.
   localparam int unsigned NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int unsigned BIT_CNT_W  = $clog2(VALUE_BITS);
   localparam int unsigned DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

   state_type              state_ff, state_in;
   logic [BIT_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_W-1:0]   dig_cnt_ff, dig_cnt_in;
   logic                   started_ff, started_in;
   dbl_ctrl_type           ctrl;
   logic [3:0]             top_digit;
   logic                   emit;

   b2da_dabble #(
      .VALUE_BITS (VALUE_BITS),
      .NUM_DIGITS (NUM_DIGITS)
   ) u_dabble (
      .clock      (clock),
      .ctrl       (ctrl),
      .load_value (req_value),
      .top_digit  (top_digit)
   );

   // A digit is sent once a nonzero digit has appeared, or when it is the final one.
   assign emit = started_ff || (top_digit != 4'd0) || (dig_cnt_ff == DIG_CNT_W'(1));

   always_comb begin
      state_in   = state_ff;
      bit_cnt_in = bit_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      started_in = started_ff;
      ctrl       = '0;
      busy       = 1'b1;
      rsp_valid  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               ctrl.load  = 1'b1;
               bit_cnt_in = BIT_CNT_W'(VALUE_BITS - 1);
               state_in   = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            ctrl.dabble = 1'b1;
            if (bit_cnt_ff == '0) begin
               dig_cnt_in = DIG_CNT_W'(NUM_DIGITS);
               started_in = 1'b0;
               state_in   = ST_EMIT;
            end else begin
               bit_cnt_in = bit_cnt_ff - 1'b1;
            end
         end
         ST_EMIT: begin
            ctrl.digit_shift = 1'b1;
            rsp_valid        = emit;
            started_in       = started_ff | emit;
            dig_cnt_in       = dig_cnt_ff - 1'b1;
            if (dig_cnt_ff == DIG_CNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_digit_char = ASCII_ZERO + {2'b00, top_digit};
   assign rsp_last_digit = (dig_cnt_ff == DIG_CNT_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         started_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         started_ff <= started_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_cnt_ff <= bit_cnt_in;
      dig_cnt_ff <= dig_cnt_in;
   end

   // Results appear only while an item is in progress.
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   // Once the first digit is sent, the rest follow without gaps.
   a_digits_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_digit |=> rsp_valid)
      else $error("gap in digit run");

   // The final digit ends the item.
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_digit |=> !busy)
      else $error("block still busy after last digit");

   // An accepted item starts conversion: the block turns busy, with no result strobe yet.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_valid)
      else $error("accepted item did not start conversion");

endmodule
